// File: rtl/sdbm_kt_pkg.sv
// Shared types and constants for the SDBM-hashed direct-mapped key table.
// Used by every module of the block; depends on nothing.
package sdbm_kt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int CFG_W       = 9;
	localparam int HASH_W      = 32;
	localparam int VAL_W       = 32;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int DIV_BITS    = 4;
	localparam int DIV_STEPS   = HASH_W / DIV_BITS;
	localparam int DIV_CW      = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		FN_LOOKUP = 3'd0,
		FN_INSERT = 3'd1,
		FN_UNSET  = 3'd2,
		FN_EXISTS = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	// one finished command handed from the hashing front to the table back end
	typedef struct packed {
		func_t             func;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  value;
	} cmd_t;

endpackage

// File: rtl/sdbm_kt_fifo.sv
// Short command queue between the hashing front and the table back end.
// Depends on sdbm_kt_pkg for the command type and depth.
module sdbm_kt_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sdbm_kt_pkg::cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output sdbm_kt_pkg::cmd_t  pop_cmd,
	output logic               empty
);

	sdbm_kt_pkg::cmd_t                   mem_q [sdbm_kt_pkg::FIFO_DEPTH];
	logic [sdbm_kt_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [sdbm_kt_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [sdbm_kt_pkg::FIFO_AW:0]       count_q;

	assign full    = (count_q == (sdbm_kt_pkg::FIFO_AW+1)'(sdbm_kt_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/sdbm_kt_front.sv
// Front end: takes key bytes, folds them into the SDBM hash and queues
// one command per finished key or clear. Depends on sdbm_kt_pkg.
module sdbm_kt_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       in_func,
	input  logic [7:0]                       in_byte,
	input  logic                             in_last,
	input  logic [sdbm_kt_pkg::VAL_W-1:0]    in_value,
	output logic                             push,
	output sdbm_kt_pkg::cmd_t                push_cmd,
	input  logic                             q_full
);

	logic [sdbm_kt_pkg::HASH_W-1:0] acc_q;
	logic [sdbm_kt_pkg::HASH_W-1:0] hash_next;
	logic                           take;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	// h * 65599 + byte, mod 2^32
	assign hash_next = {24'd0, in_byte} + (acc_q << 6) + (acc_q << 16) - acc_q;

	always_comb begin
		push           = 1'b0;
		push_cmd.func  = sdbm_kt_pkg::FN_CLEAR;
		push_cmd.hash  = hash_next;
		push_cmd.value = in_value;
		if (take) begin
			unique case (in_func)
				sdbm_kt_pkg::FN_CLEAR: begin
					push = 1'b1;
				end
				sdbm_kt_pkg::FN_LOOKUP, sdbm_kt_pkg::FN_INSERT,
				sdbm_kt_pkg::FN_UNSET, sdbm_kt_pkg::FN_EXISTS: begin
					push          = in_last;
					push_cmd.func = sdbm_kt_pkg::func_t'(in_func);
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			unique case (in_func)
				sdbm_kt_pkg::FN_CLEAR: begin
					acc_q <= '0;
				end
				sdbm_kt_pkg::FN_LOOKUP, sdbm_kt_pkg::FN_INSERT,
				sdbm_kt_pkg::FN_UNSET, sdbm_kt_pkg::FN_EXISTS: begin
					acc_q <= in_last ? '0 : hash_next;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/sdbm_kt_back.sv
// Back end: reduces the hash modulo the slot count (4 bits a cycle), then
// reads the value table, updates it on insert or unset and registers the
// result word; a clear only resets the valid bits. Depends on sdbm_kt_pkg.
module sdbm_kt_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sdbm_kt_pkg::CFG_W-1:0]       slots_in_use,
	input  logic                                q_empty,
	input  sdbm_kt_pkg::cmd_t                   q_cmd,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sdbm_kt_pkg::VAL_W-1:0]       out_read_value,
	output logic                                out_present,
	output logic [7:0]                          out_slot_index
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_WB
	} state_t;

	state_t                               state_q;
	sdbm_kt_pkg::func_t                   func_q;
	logic [sdbm_kt_pkg::HASH_W-1:0]       dividend_q;
	logic [sdbm_kt_pkg::VAL_W-1:0]        value_q;
	logic [sdbm_kt_pkg::CNT_W-1:0]        rem_q;
	logic [sdbm_kt_pkg::DIV_CW-1:0]       step_q;
	logic [sdbm_kt_pkg::CNT_W-1:0]        n_act;
	logic [sdbm_kt_pkg::CNT_W-1:0]        rem_next;
	logic [sdbm_kt_pkg::SLOT_W-1:0]       slot;
	logic [sdbm_kt_pkg::TABLE_DEPTH-1:0]  valid_q;
	logic [sdbm_kt_pkg::VAL_W-1:0]        mem [sdbm_kt_pkg::TABLE_DEPTH];
	logic [sdbm_kt_pkg::VAL_W-1:0]        rdata_q;
	logic [sdbm_kt_pkg::VAL_W-1:0]        old_val;
	logic                                 out_free;
	logic                                 wr_en;
	logic [sdbm_kt_pkg::VAL_W-1:0]        wr_data;

	// zero acts as one, anything above the table depth as the depth
	always_comb begin
		if (slots_in_use == '0) begin
			n_act = sdbm_kt_pkg::CNT_W'(1);
		end else if (sdbm_kt_pkg::CNT_W'(slots_in_use) >
				sdbm_kt_pkg::CNT_W'(sdbm_kt_pkg::TABLE_DEPTH)) begin
			n_act = sdbm_kt_pkg::CNT_W'(sdbm_kt_pkg::TABLE_DEPTH);
		end else begin
			n_act = sdbm_kt_pkg::CNT_W'(slots_in_use);
		end
	end

	// restoring remainder, one dividend bit per step
	always_comb begin
		logic [sdbm_kt_pkg::CNT_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < sdbm_kt_pkg::DIV_BITS; i++) begin
			r = {r[sdbm_kt_pkg::SLOT_W-1:0], dividend_q[sdbm_kt_pkg::HASH_W-1-i]};
			if (r >= n_act) begin
				r = r - n_act;
			end
		end
		rem_next = r;
	end

	assign slot      = rem_q[sdbm_kt_pkg::SLOT_W-1:0];
	assign old_val   = valid_q[slot] ? rdata_q : '0;
	assign out_free  = !out_valid || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign wr_en     = (state_q == ST_WB) && out_free &&
		(func_q == sdbm_kt_pkg::FN_INSERT || func_q == sdbm_kt_pkg::FN_UNSET);
	assign wr_data   = (func_q == sdbm_kt_pkg::FN_INSERT) ? value_q : '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rdata_q <= mem[slot];
		end
		if (wr_en) begin
			mem[slot] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			valid_q        <= '0;
			out_valid      <= 1'b0;
			func_q         <= sdbm_kt_pkg::FN_LOOKUP;
			dividend_q     <= '0;
			value_q        <= '0;
			rem_q          <= '0;
			step_q         <= '0;
			out_read_value <= '0;
			out_present    <= 1'b0;
			out_slot_index <= '0;
		end else begin
			if (state_q == ST_WB && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						func_q     <= q_cmd.func;
						dividend_q <= q_cmd.hash;
						value_q    <= q_cmd.value;
						rem_q      <= '0;
						step_q     <= '0;
						if (q_cmd.func == sdbm_kt_pkg::FN_CLEAR) begin
							valid_q <= '0;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q      <= rem_next;
					dividend_q <= dividend_q << sdbm_kt_pkg::DIV_BITS;
					step_q     <= step_q + 1'b1;
					if (step_q == sdbm_kt_pkg::DIV_CW'(sdbm_kt_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (out_free) begin
						out_read_value <= (func_q == sdbm_kt_pkg::FN_LOOKUP) ? old_val : '0;
						out_present    <= (old_val != '0);
						out_slot_index <= 8'(slot);
						if (wr_en) begin
							valid_q[slot] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/sdbm_direct_mapped_key_table.sv
// SDBM-hashed direct-mapped key table. Key bytes stream in one word per
// cycle while the command queue has room; each key-final word (lookup,
// insert, unset, exists) takes the back end through a queue pop, the
// 4-bit-per-cycle modulo unit, one table read and a write/result step that
// waits for the result output to be free. A clear empties all slots at once
// through per-slot valid bits, so no clearing pass follows reset. The 4-entry
// command queue lets up to four keys finish hashing while the back end is busy.
// Depends on sdbm_kt_pkg, sdbm_kt_front, sdbm_kt_fifo, sdbm_kt_back.
module sdbm_direct_mapped_key_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,    // slots_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,      // key_byte[7:0], store_value[39:8]
	input  logic        s_tlast,      // key_last
	input  logic [2:0]  s_tuser,      // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata       // read_value[31:0], present[32], slot_index[40:33]
);

	logic [sdbm_kt_pkg::CFG_W-1:0] slots_q;
	logic                          push;
	sdbm_kt_pkg::cmd_t             push_cmd;
	logic                          q_full;
	logic                          q_pop;
	sdbm_kt_pkg::cmd_t             q_cmd;
	logic                          q_empty;
	logic [31:0]                   read_value;
	logic                          present;
	logic [7:0]                    slot_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= sdbm_kt_pkg::CFG_W'(256);
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	sdbm_kt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.in_byte  (s_tdata[7:0]),
		.in_last  (s_tlast),
		.in_value (s_tdata[39:8]),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	sdbm_kt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_cmd),
		.empty    (q_empty)
	);

	sdbm_kt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.slots_in_use   (slots_q),
		.q_empty        (q_empty),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_read_value (read_value),
		.out_present    (present),
		.out_slot_index (slot_index)
	);

	assign m_tdata = {7'd0, slot_index, present, read_value};

endmodule
